/* rtl/minmax_range_rescale_unit_macros.svh */
// Assertion macros used by the checker file of the rescale unit.
`ifndef MINMAX_RANGE_RESCALE_UNIT_MACROS_SVH
`define MINMAX_RANGE_RESCALE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and off while rst is high.
`define MRR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("minmax_range_rescale_unit: same-cycle check failed");

// Next-cycle implication, sampled on clk and off while rst is high.
`define MRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("minmax_range_rescale_unit: next-cycle check failed");

`endif

/* rtl/mrr_pkg.sv */
// Shared constants and types of the min-max rescale unit.
package mrr_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 6;
  localparam int PADDR_W     = 3;
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int M_TDATA_W   = 40;
  localparam int M_TUSER_W   = 2;

  localparam logic [DATA_W-1:0] MIN_RESET   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MAX_RESET   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] START_RESET = 32'h0000_0000;
  localparam logic [DATA_W-1:0] END_RESET   = 32'h0001_0000;

  // Register indexes, taken from paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_OUT_START = 1'b0;
  localparam logic [PADDR_W-3:0] REG_OUT_END   = 1'b1;

  // Divider request: start pulse with operands
  typedef struct packed {
    logic                  start;
    logic [2*DATA_W-1:0]   dividend;
    logic [DATA_W-1:0]     divisor;
  } div_ctrl_t;

  // Divider status: done pulse with the held quotient
  typedef struct packed {
    logic                  done;
    logic [DATA_W-1:0]     quotient;
  } div_stat_t;

endpackage

/* rtl/minmax_range_rescale_unit.sv */
// Top level: sample store, running min/max, sequencer and output register.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata = sample, s_tlast = last_in
//  m_*     | out | m_tvalid/m_tready  | m_tdata = scaled, index_out;
//          |     |                    | m_tlast = last_out; m_tuser = flat, overflowed
//  apb     | in  | psel/penable/pwrite| 0x0 out_start, 0x4 out_end (pready tied high)
//
// Loading accepts one sample per cycle; s_tready is high only while loading.
// Each result passes through read, multiply, divider launch and 32 divider steps
// before it shows on m_*; a flat vector skips the multiply and the divider.
// The 32-step shared divider serves every result in turn.
// rst is synchronous; no clearing pass runs, the store is read only where written.
// A stalled m_tready holds the result and the whole sequencer.
module minmax_range_rescale_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mrr_pkg::DATA_W-1:0]        s_tdata,   // [31:0] sample
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mrr_pkg::M_TDATA_W-1:0]     m_tdata,   // [31:0] scaled, [37:32] index_out
  output logic                              m_tlast,
  output logic [mrr_pkg::M_TUSER_W-1:0]     m_tuser,   // [0] flat, [1] overflowed
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mrr_pkg::PADDR_W-1:0]       paddr,
  input  logic [mrr_pkg::DATA_W-1:0]        pwdata,
  output logic [mrr_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import mrr_pkg::*;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_DGO   = 6'b001000,
    ST_DWAIT = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  localparam logic signed [DATA_W+1:0] SAT_HI = 34'sh0_7FFF_FFFF;
  localparam logic signed [DATA_W+1:0] SAT_LO = -34'sh0_8000_0000;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          k;
  logic signed [DATA_W-1:0]  run_min;
  logic signed [DATA_W-1:0]  run_max;
  logic                      drop;
  logic signed [DATA_W-1:0]  out_start;
  logic signed [DATA_W-1:0]  out_end;

  logic [DATA_W-1:0]         ram_rdata;
  logic [2*DATA_W-1:0]       prod;

  logic [DATA_W-1:0]         scaled_q;
  logic [IDX_W-1:0]          index_q;
  logic                      last_q;
  logic                      flat_q;
  logic                      ovf_q;

  logic                      s_accept;
  logic                      m_accept;
  logic                      cfg_wr;
  logic                      full;
  logic                      flat;
  logic                      last_k;
  logic signed [DATA_W-1:0]  sample_v;
  logic signed [DATA_W:0]    span;
  logic [DATA_W-1:0]         mag;
  logic signed [DATA_W:0]    vspan_w;
  logic signed [DATA_W:0]    num_w;
  logic signed [DATA_W+1:0]  q_signed;
  logic signed [DATA_W+1:0]  res_w;
  logic [DATA_W-1:0]         res_sat;
  div_ctrl_t                 div_ctrl;
  div_stat_t                 div_stat;

  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign s_tready = (state == ST_LOAD);
  assign pready   = 1'b1;
  assign full     = (count == CNT_W'(MAX_SAMPLES));
  assign flat     = (run_max <= run_min);
  assign last_k   = (CNT_W'(k + 1'b1) == count);
  assign sample_v = s_tdata;

  // Span arithmetic, exact in one extra bit
  always_comb begin
    span    = {out_end[DATA_W-1], out_end} - {out_start[DATA_W-1], out_start};
    mag     = span[DATA_W] ? DATA_W'(-span) : span[DATA_W-1:0];
    vspan_w = {run_max[DATA_W-1], run_max} - {run_min[DATA_W-1], run_min};
    num_w   = {ram_rdata[DATA_W-1], ram_rdata} - {run_min[DATA_W-1], run_min};
  end

  // Apply the sign of the span, add the start and clamp
  always_comb begin
    q_signed = $signed({2'b00, div_stat.quotient});
    if (span[DATA_W]) begin
      q_signed = -q_signed;
    end
    res_w = q_signed + $signed({{2{out_start[DATA_W-1]}}, out_start});
    if (res_w > SAT_HI) begin
      res_sat = SAT_HI[DATA_W-1:0];
    end else if (res_w < SAT_LO) begin
      res_sat = SAT_LO[DATA_W-1:0];
    end else begin
      res_sat = res_w[DATA_W-1:0];
    end
  end

  // Divider launch
  assign div_ctrl.start    = (state == ST_DGO);
  assign div_ctrl.dividend = prod;
  assign div_ctrl.divisor  = vspan_w[DATA_W-1:0];

  mrr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (s_accept && !full),
    .waddr (count[ADDR_W-1:0]),
    .wdata (s_tdata),
    .raddr (k[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  mrr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .stat (div_stat)
  );

  // Sequencer, vector state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      k         <= '0;
      run_min   <= MIN_RESET;
      run_max   <= MAX_RESET;
      drop      <= 1'b0;
      m_tvalid  <= 1'b0;
      out_start <= START_RESET;
      out_end   <= END_RESET;
    end else begin
      if (cfg_wr) begin
        case (paddr[PADDR_W-1:2])
          REG_OUT_START: out_start <= pwdata;
          REG_OUT_END:   out_end   <= pwdata;
          default: ;
        endcase
      end
      case (state)
        ST_LOAD: begin
          if (s_accept) begin
            if (full) begin
              drop <= 1'b1;
            end else begin
              count <= count + 1'b1;
              if (sample_v < run_min) run_min <= sample_v;
              if (sample_v > run_max) run_max <= sample_v;
            end
            if (s_tlast) begin
              k     <= '0;
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          // Flat vector skips the arithmetic
          if (flat) begin
            m_tvalid <= 1'b1;
            state    <= ST_OUT;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL:   state <= ST_DGO;
        ST_DGO:   state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_stat.done) begin
            m_tvalid <= 1'b1;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_accept) begin
            m_tvalid <= 1'b0;
            if (last_k) begin
              count   <= '0;
              run_min <= MIN_RESET;
              run_max <= MAX_RESET;
              drop    <= 1'b0;
              state   <= ST_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Product and output payload
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= num_w[DATA_W-1:0] * mag;
    end
    if ((state == ST_READ && flat) || (state == ST_DWAIT && div_stat.done)) begin
      scaled_q <= (state == ST_READ) ? out_start : res_sat;
      index_q  <= IDX_W'(k);
      last_q   <= last_k;
      flat_q   <= (state == ST_READ);
      ovf_q    <= drop;
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_OUT_START: prdata = out_start;
      REG_OUT_END:   prdata = out_end;
      default:       prdata = '0;
    endcase
  end

  assign m_tdata = {{(M_TDATA_W - DATA_W - IDX_W){1'b0}}, index_q, scaled_q};
  assign m_tlast = last_q;
  assign m_tuser = {ovf_q, flat_q};

endmodule

/* rtl/mrr_ram.sv */
// Generic single-port-write, registered-read RAM.
module mrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry; the entry read appears on rdata in the next cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mrr_div.sv */
// Restoring divider, one quotient bit per cycle, 64-by-32 with 32-bit quotient.
module mrr_div (
  input  logic              clk,
  input  logic              rst,
  input  mrr_pkg::div_ctrl_t ctrl,
  output mrr_pkg::div_stat_t stat
);
  import mrr_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    rem_next;
  logic [DATA_W-1:0]    quo_next;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      dvs;

  // One shift-compare-subtract step
  always_comb begin
    trial = {rem, quo[DATA_W-1]};
    dvs   = {1'b0, ctrl.divisor};
    if (trial >= dvs) begin
      rem_next = DATA_W'(trial - dvs);
      quo_next = {quo[DATA_W-2:0], 1'b1};
    end else begin
      rem_next = trial[DATA_W-1:0];
      quo_next = {quo[DATA_W-2:0], 1'b0};
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load the high half as partial remainder, shift the low half through
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= ctrl.dividend[2*DATA_W-1:DATA_W];
      quo <= ctrl.dividend[DATA_W-1:0];
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign stat.done     = done;
  assign stat.quotient = quo;

endmodule

/* rtl/mrr_checker.sv */
// Port-level checker for the rescale unit, bound to the top level.
`include "minmax_range_rescale_unit_macros.svh"

module mrr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mrr_pkg::M_TDATA_W-1:0] m_tdata
);

  // Input side is closed while a result is offered
  `MRR_ASSERT_IMPL(a_no_overlap, m_tvalid, !s_tready)

  // Closing item of a vector starts the output run
  `MRR_ASSERT_NEXT(a_last_closes, s_tvalid && s_tready && s_tlast, !s_tready)

  // Stalled result holds its data
  `MRR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind minmax_range_rescale_unit mrr_checker u_mrr_checker (.*);

/* verif/tb.sv */
// Testbench for the min-max rescale unit: directed table, random vectors, scoreboard.
`timescale 1ns / 1ps

module tb;
  import mrr_pkg::*;

  // One rescaled result as it leaves the block
  typedef struct packed {
    logic signed [DATA_W-1:0] scaled;
    logic [IDX_W-1:0]         index;
    logic                     last;
    logic                     flat;
    logic                     dropped;
  } rescale_t;

  // One row of the directed table; if wr_range is set, the range is written before the row's item
  typedef struct packed {
    bit              wr_range;
    logic [31:0]     range_lo;
    logic [31:0]     range_hi;
    logic [31:0]     sample;
    bit              last;
    bit              typed;
    logic [31:0]     exp_scaled;
    bit              exp_flat;
  } dir_row_t;

  localparam int N_DIR = 20;
  localparam int N_ITEMS = 130;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 60;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // single sample under reset range: flat, start
    '{1'b0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0 | 1'b1},
    // sample extremes map to the range ends
    '{1'b0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0001_0000, 1'b0},
    // all samples equal
    '{1'b0, 32'h0, 32'h0, 32'h0005_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
    '{1'b0, 32'h0, 32'h0, 32'h0005_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
    '{1'b0, 32'h0, 32'h0, 32'h0005_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
    // ordinary vector
    '{1'b0, 32'h0, 32'h0, 32'h0001_2345, 1'b0, 1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'hFFFE_8000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0030_0000, 1'b1, 1'b0, 32'h0, 1'b0},
    // full output range, full input range
    '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
    // reversed output range
    '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0064, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'hFFFF_FF9C, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0000_0007, 1'b1, 1'b0, 32'h0, 1'b0},
    // empty output range
    '{1'b1, 32'h1234_0000, 32'h1234_0000, 32'h0000_0001, 1'b0, 1'b1, 32'h1234_0000, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0000_0002, 1'b1, 1'b1, 32'h1234_0000, 1'b0},
    // symmetric range, mixed signs
    '{1'b1, 32'hFFFF_0000, 32'h0001_0000, 32'h4000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'hC000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0123_4567, 1'b1, 1'b0, 32'h0, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [DATA_W-1:0]    s_tdata = '0;     // [31:0] sample
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;          // [31:0] scaled, [37:32] index_out
  logic                 m_tlast;
  logic [M_TUSER_W-1:0] m_tuser;          // [0] flat, [1] overflowed
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  minmax_range_rescale_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // Mirror of the block's vector state and output range
  logic signed [DATA_W-1:0] vec_store [MAX_SAMPLES];
  bit                       vec_typed [MAX_SAMPLES];
  logic signed [DATA_W-1:0] vec_typed_scaled [MAX_SAMPLES];
  bit                       vec_typed_flat [MAX_SAMPLES];
  int                       vec_count = 0;
  logic signed [DATA_W-1:0] vec_min = MIN_RESET;
  logic signed [DATA_W-1:0] vec_max = MAX_RESET;
  bit                       vec_dropped = 1'b0;
  logic signed [DATA_W-1:0] range_start = START_RESET;
  logic signed [DATA_W-1:0] range_end = END_RESET;

  rescale_t rescaled_due [$];
  int       errors = 0;
  int       items_sent = 0;
  int       snd_idle_pct = 10;
  int       rcv_idle_pct = 74;
  int       hold_req = 0;
  int       hold_ack = 0;
  int       hold_left = 0;

  // Clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Rescale one stored sample into the current output range
  function automatic logic signed [DATA_W-1:0] rescale_sample(input logic signed [DATA_W-1:0] v);
    longint          span;
    longint          res;
    longint unsigned num;
    longint unsigned mag;
    longint unsigned vspan;
    longint unsigned quo;
    span  = longint'(range_end) - longint'(range_start);
    vspan = longint'(vec_max) - longint'(vec_min);
    num   = longint'(v) - longint'(vec_min);
    mag   = (span < 0) ? -span : span;
    quo   = (num * mag) / vspan;
    res   = (span < 0) ? -longint'(quo) : longint'(quo);
    res   = res + longint'(range_start);
    if (res > 64'sd2147483647)
      res = 64'sd2147483647;
    if (res < -64'sd2147483648)
      res = -64'sd2147483648;
    return res[DATA_W-1:0];
  endfunction

  // Load one accepted sample; on the last one, queue the whole rescaled vector
  task automatic take_sample(input logic signed [DATA_W-1:0] smp, input bit lst,
                             input bit typed, input logic signed [DATA_W-1:0] t_scaled,
                             input bit t_flat);
    rescale_t r;
    bit       is_flat;
    if (vec_count < MAX_SAMPLES) begin
      vec_store[vec_count]        = smp;
      vec_typed[vec_count]        = typed;
      vec_typed_scaled[vec_count] = t_scaled;
      vec_typed_flat[vec_count]   = t_flat;
      vec_count++;
      if (smp < vec_min)
        vec_min = smp;
      if (smp > vec_max)
        vec_max = smp;
    end else begin
      vec_dropped = 1'b1;
    end
    if (lst) begin
      is_flat = (vec_max <= vec_min);
      for (int k = 0; k < vec_count; k++) begin
        r.scaled  = is_flat ? range_start : rescale_sample(vec_store[k]);
        r.flat    = is_flat;
        if (vec_typed[k]) begin
          r.scaled = vec_typed_scaled[k];
          r.flat   = vec_typed_flat[k];
        end
        r.index   = k[IDX_W-1:0];
        r.last    = (k == vec_count - 1);
        r.dropped = vec_dropped;
        rescaled_due.push_back(r);
      end
      vec_count   = 0;
      vec_min     = MIN_RESET;
      vec_max     = MAX_RESET;
      vec_dropped = 1'b0;
    end
  endtask

  // Offer one item, idling first at the current rate, and wait for acceptance
  task automatic send_sample(input logic [DATA_W-1:0] smp, input bit lst, input bit typed,
                             input logic [DATA_W-1:0] t_scaled, input bit t_flat);
    if (items_sent < 45) begin
      snd_idle_pct = 10;
      rcv_idle_pct = 74;
    end else if (items_sent < 90) begin
      snd_idle_pct = 74;
      rcv_idle_pct = 10;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    take_sample(smp, lst, typed, t_scaled, t_flat);
    items_sent++;
  endtask

  // Drop valid and wait until every result is out and the sequencer has settled
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (rescaled_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both range registers back to back over APB
  task automatic set_output_range(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_OUT_START, 2'b00};
    pwdata  <= lo;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    paddr   <= {REG_OUT_END, 2'b00};
    pwdata  <= hi;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    range_start = lo;
    range_end   = hi;
  endtask

  // Draw one sample for a vector of the given flavor
  function automatic logic [DATA_W-1:0] draw_sample(input int flavor, input logic [DATA_W-1:0] base);
    case (flavor)
      0: begin
        return $urandom;
      end
      1: begin
        return base + $urandom_range(4095);
      end
      2: begin
        return base;
      end
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Compare one field and report a mismatch
  function automatic void check_field(input string fname, input logic [DATA_W-1:0] e,
                                      input logic [DATA_W-1:0] g);
    if (e !== g) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, e, g);
      errors++;
    end
  endfunction

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    rescale_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (rescaled_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
        errors++;
      end else begin
        exp_r = rescaled_due.pop_front();
        check_field("scaled", exp_r.scaled, m_tdata[31:0]);
        check_field("index_out", exp_r.index, m_tdata[37:32]);
        check_field("last_out", exp_r.last, m_tlast);
        check_field("flat", exp_r.flat, m_tuser[0]);
        check_field("overflowed", exp_r.dropped, m_tuser[1]);
      end
    end
  end

  // Stimulus
  initial begin
    int                 len;
    int                 flavor;
    bit                 ovf_done;
    logic [DATA_W-1:0]  base;
    logic [DATA_W-1:0]  lo;
    ovf_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].wr_range) begin
        wait_idle();
        set_output_range(DIR_ROWS[i].range_lo, DIR_ROWS[i].range_hi);
      end
      send_sample(DIR_ROWS[i].sample, DIR_ROWS[i].last, DIR_ROWS[i].typed,
                  DIR_ROWS[i].exp_scaled, DIR_ROWS[i].exp_flat);
    end

    // Random vectors, one over capacity
    while (items_sent < N_ITEMS) begin
      // keep offering items while a long hold-off is pending
      if ($urandom_range(2) == 0 && hold_req == hold_ack && hold_left == 0) begin
        wait_idle();
        lo = $urandom;
        case ($urandom_range(4))
          0: set_output_range(lo, $urandom);
          1: set_output_range(lo, lo);
          2: set_output_range(32'h8000_0000, 32'h7FFF_FFFF);
          3: set_output_range(32'h7FFF_FFFF, 32'h8000_0000);
          default: set_output_range(32'h0000_0000, 32'h0001_0000);
        endcase
      end
      if (!ovf_done && items_sent >= 40)
        len = MAX_SAMPLES + 3;
      else if ($urandom_range(9) == 0)
        len = $urandom_range(24, 9);
      else
        len = $urandom_range(6, 1);
      flavor = $urandom_range(3);
      base   = $urandom;
      for (int i = 0; i < len; i++)
        send_sample(draw_sample(flavor, base), i == len - 1, 1'b0, '0, 1'b0);
      // stall the output long enough to back up the next vector
      if (len > MAX_SAMPLES) begin
        ovf_done = 1'b1;
        hold_req++;
      end
    end

    // Drain and report
    s_tvalid <= 1'b0;
    while (rescaled_due.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/mrr_pkg.sv
rtl/mrr_ram.sv
rtl/mrr_div.sv
rtl/minmax_range_rescale_unit.sv
rtl/mrr_checker.sv
verif/tb.sv
